>>> hw/rtl/gst_pkg.sv
// ----------------------------------------------------------------------------
// gst_pkg
// Shared widths and the gaussian cdf lookup for the shadow texel generator.
// ----------------------------------------------------------------------------
package gst_pkg;

  // field widths
  localparam int unsigned FuncW  = 1;
  localparam int unsigned CoordW = 6;
  localparam int unsigned AlphaW = 8;
  localparam int unsigned RatioW = 6;

  // internal widths, sized for textures of up to 128 texels
  localparam int unsigned DeltaW = 7;   // distance to the solid corner in texels
  localparam int unsigned SumW   = 15;  // dx*dx + dy*dy
  localparam int unsigned RootW  = 16;  // distance, 8 fraction bits
  localparam int unsigned RemW   = 20;  // square root remainder
  localparam int unsigned SolidW = 15;
  localparam int unsigned SigW   = 15;  // scaled sigma
  localparam int unsigned NumW   = 22;  // |dist - solid| * 32
  localparam int unsigned QuotW  = 8;

  // gaussian cdf, 255 fully shadowed down to 0
  localparam logic [7:0] CdfTable [256] = '{
    8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
    8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
    8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
    8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
    8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
    8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
    8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
    8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd254,
    8'd254,8'd254,8'd254,8'd254,8'd254,8'd254,8'd254,8'd253,
    8'd253,8'd253,8'd253,8'd253,8'd252,8'd252,8'd252,8'd251,
    8'd251,8'd250,8'd250,8'd249,8'd248,8'd248,8'd247,8'd246,
    8'd245,8'd244,8'd243,8'd242,8'd241,8'd239,8'd238,8'd237,
    8'd235,8'd233,8'd231,8'd230,8'd227,8'd225,8'd223,8'd221,
    8'd218,8'd216,8'd213,8'd210,8'd207,8'd204,8'd201,8'd197,
    8'd194,8'd190,8'd187,8'd183,8'd179,8'd175,8'd171,8'd167,
    8'd163,8'd158,8'd154,8'd150,8'd145,8'd141,8'd136,8'd132,
    8'd128,8'd123,8'd119,8'd114,8'd110,8'd105,8'd101,8'd97,
    8'd92, 8'd88, 8'd84, 8'd80, 8'd76, 8'd72, 8'd68, 8'd65,
    8'd61, 8'd58, 8'd54, 8'd51, 8'd48, 8'd45, 8'd42, 8'd39,
    8'd37, 8'd34, 8'd32, 8'd30, 8'd28, 8'd25, 8'd24, 8'd22,
    8'd20, 8'd18, 8'd17, 8'd16, 8'd14, 8'd13, 8'd12, 8'd11,
    8'd10, 8'd9,  8'd8,  8'd7,  8'd7,  8'd6,  8'd5,  8'd5,
    8'd4,  8'd4,  8'd3,  8'd3,  8'd3,  8'd2,  8'd2,  8'd2,
    8'd2,  8'd2,  8'd1,  8'd1,  8'd1,  8'd1,  8'd1,  8'd1,
    8'd1,  8'd1,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0
  };

  // square root stage payload
  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [SumW-1:0]  sum;
    logic [RootW-1:0] edist;
    logic [RootW-1:0] root;
    logic [RemW-1:0]  rem;
  } sqrt_stage_t;

  // division stage payload
  typedef struct packed {
    logic             neg;
    logic             sat;
    logic [NumW-1:0]  rem;
    logic [QuotW-1:0] quot;
  } div_stage_t;

endpackage

>>> hw/rtl/gst_if.sv
// ----------------------------------------------------------------------------
// gst channel interfaces
// Texel request, alpha result and configuration write channels.
// ----------------------------------------------------------------------------
interface gst_in_if;
  logic                          valid;
  logic                          ready;
  logic [gst_pkg::FuncW-1:0]     func;
  logic [gst_pkg::CoordW-1:0]    texel_x;
  logic [gst_pkg::CoordW-1:0]    texel_y;
  modport source (output valid, func, texel_x, texel_y, input ready);
  modport sink   (input valid, func, texel_x, texel_y, output ready);
endinterface

interface gst_out_if;
  logic                          valid;
  logic                          ready;
  logic [gst_pkg::AlphaW-1:0]    alpha;
  modport source (output valid, alpha, input ready);
  modport sink   (input valid, alpha, output ready);
endinterface

interface gst_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gst_pkg::RatioW-1:0]    data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> hw/rtl/gaussian_shadow_texel_generator.sv
// ----------------------------------------------------------------------------
// gaussian_shadow_texel_generator
// Streams 8-bit gaussian shadow alpha values for corner and edge texels.
// ----------------------------------------------------------------------------
// One texel transaction is accepted every cycle unless the result side
// stalls. Each texel passes through the offset and square registers, the
// one-bit-per-stage square root, the offset from the solid region and the
// one-bit-per-stage divide by the scaled sigma, then the cdf lookup into
// the output register. A stall on the result side holds the whole pipeline.
// Writing solid_ratio looks up solid size and scaled sigma in constant
// tables, so it takes effect on the next cycle.
module gaussian_shadow_texel_generator #(
  parameter int unsigned TEX_DIM = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gst_cfg_if.sink     cfg_i,
  gst_in_if.sink      in_i,
  gst_out_if.source   out_o
);

  localparam int unsigned SqrtN = gst_pkg::RootW;
  localparam int unsigned DivN  = gst_pkg::QuotW;
  localparam logic [gst_pkg::DeltaW-1:0] MaxCoord = gst_pkg::DeltaW'(TEX_DIM - 1);

  // constant tables of solid size and scaled sigma per ratio
  logic [gst_pkg::SolidW-1:0] solid_lut [64];
  logic [gst_pkg::SigW-1:0]   s2_lut [64];
  for (genvar r = 0; r < 64; r++) begin : g_lut
    localparam int Sol  = r * TEX_DIM * 256 / (TEX_DIM - 1);
    localparam int Blr0 = TEX_DIM * 256 - Sol;
    localparam int Blr  = (Blr0 < 256) ? 256 : Blr0;
    localparam int Sg0  = Blr * 45 / 100;
    localparam int Sg   = (Sg0 < 128) ? 128 : Sg0;
    localparam int S20  = Sg * 1414 / 1000;
    localparam int S2   = (S20 < 1) ? 1 : S20;
    assign solid_lut[r] = gst_pkg::SolidW'(Sol);
    assign s2_lut[r]    = gst_pkg::SigW'(S2);
  end

  // configuration register
  logic [gst_pkg::SolidW-1:0] solid_q;
  logic [gst_pkg::SigW-1:0]   s2_q;
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      solid_q <= solid_lut[0];
      s2_q    <= s2_lut[0];
    end else if (cfg_i.valid) begin
      solid_q <= solid_lut[cfg_i.data];
      s2_q    <= s2_lut[cfg_i.data];
    end
  end

  // global pipeline advance
  logic en;
  logic out_valid_q;
  assign en       = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // stage a: offsets from the solid corner
  logic                        a_valid_q;
  logic [gst_pkg::FuncW-1:0]   a_func_q;
  logic [gst_pkg::DeltaW-1:0]  a_dx_q, a_dy_q;
  logic [gst_pkg::DeltaW-1:0]  x_sat, y_sat;
  always_comb begin
    x_sat = gst_pkg::DeltaW'(in_i.texel_x);
    y_sat = gst_pkg::DeltaW'(in_i.texel_y);
    if (x_sat > MaxCoord) x_sat = MaxCoord;
    if (y_sat > MaxCoord) y_sat = MaxCoord;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_func_q <= in_i.func;
      a_dx_q   <= MaxCoord - x_sat;
      a_dy_q   <= MaxCoord - y_sat;
    end
  end

  // stage b: squared radius and edge distance, feeding the root pipeline
  gst_pkg::sqrt_stage_t sq_q [SqrtN+1];
  logic                 sq_valid_q [SqrtN+1];
  logic [2*gst_pkg::DeltaW-1:0] dx2, dy2;
  assign dx2 = a_dx_q * a_dx_q;
  assign dy2 = a_dy_q * a_dy_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0].func  <= a_func_q;
      sq_q[0].sum   <= gst_pkg::SumW'({1'b0, dx2} + {1'b0, dy2});
      sq_q[0].edist <= {1'b0, a_dx_q, 8'h00};
      sq_q[0].root  <= '0;
      sq_q[0].rem   <= '0;
    end
  end

  // square root, one result bit per stage over sum << 16
  for (genvar k = 0; k < SqrtN; k++) begin : g_sqrt
    logic [31:0]               rad;
    logic [gst_pkg::RemW-1:0]  rem_sh, trial;
    gst_pkg::sqrt_stage_t      nxt;
    assign rad = {1'b0, sq_q[k].sum, 16'h0000};
    always_comb begin
      nxt    = sq_q[k];
      rem_sh = {sq_q[k].rem[gst_pkg::RemW-3:0], rad[31-2*k -: 2]};
      trial  = {2'b00, sq_q[k].root, 2'b01};
      if (rem_sh >= trial) begin
        nxt.rem  = rem_sh - trial;
        nxt.root = {sq_q[k].root[gst_pkg::RootW-2:0], 1'b1};
      end else begin
        nxt.rem  = rem_sh;
        nxt.root = {sq_q[k].root[gst_pkg::RootW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) sq_q[k+1] <= nxt;
    end
  end

  // offset from the solid region, sign and magnitude
  gst_pkg::div_stage_t dv_q [DivN+1];
  logic                dv_valid_q [DivN+1];
  logic [gst_pkg::RootW-1:0]  dist_fx;
  logic [gst_pkg::RootW:0]    diff, mag;
  logic [gst_pkg::NumW-1:0]   num;
  assign dist_fx = sq_q[SqrtN].func[0] ? sq_q[SqrtN].edist : sq_q[SqrtN].root;
  assign diff = {1'b0, dist_fx} - {2'b00, solid_q};
  assign mag  = diff[gst_pkg::RootW] ? (~diff + 1'b1) : diff;
  assign num  = {mag, 5'b00000};
  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0].neg  <= diff[gst_pkg::RootW];
      dv_q[0].sat  <= {1'b0, num} >= {s2_q, 8'h00};
      dv_q[0].rem  <= num;
      dv_q[0].quot <= '0;
    end
  end

  // restoring divide by scaled sigma, one quotient bit per stage
  for (genvar j = 0; j < DivN; j++) begin : g_div
    logic [gst_pkg::NumW-1:0] dsr;
    gst_pkg::div_stage_t      nxt;
    assign dsr = gst_pkg::NumW'(s2_q) << (DivN - 1 - j);
    always_comb begin
      nxt = dv_q[j];
      if (dv_q[j].rem >= dsr) begin
        nxt.rem = dv_q[j].rem - dsr;
        nxt.quot[DivN-1-j] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) dv_q[j+1] <= nxt;
    end
  end

  // table index with clamping, then lookup
  logic [gst_pkg::QuotW-1:0]  quot;
  logic [7:0]                 idx;
  logic [gst_pkg::AlphaW-1:0] alpha_q;
  assign quot = dv_q[DivN].sat ? '1 : dv_q[DivN].quot;
  always_comb begin
    if (dv_q[DivN].neg) begin
      idx = quot[7] ? 8'd0 : 8'd128 - quot;
    end else begin
      idx = quot[7] ? 8'd255 : 8'd128 + quot;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) alpha_q <= gst_pkg::CdfTable[idx];
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i <= SqrtN; i++) sq_valid_q[i] <= 1'b0;
      for (int i = 0; i <= DivN; i++) dv_valid_q[i] <= 1'b0;
    end else if (en) begin
      a_valid_q     <= in_i.valid;
      sq_valid_q[0] <= a_valid_q;
      for (int i = 0; i < SqrtN; i++) sq_valid_q[i+1] <= sq_valid_q[i];
      dv_valid_q[0] <= sq_valid_q[SqrtN];
      for (int i = 0; i < DivN; i++) dv_valid_q[i+1] <= dv_valid_q[i];
      out_valid_q   <= dv_valid_q[DivN];
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.alpha = alpha_q;

endmodule
